>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property with reset disable.
`define PLA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
// Checked property that also holds during reset.
`define PLA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define PLA_ASSERT(lbl, clk, rstn, prop)
`define PLA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> sv/pla_pkg.sv
// ----------------------------------------------------------------------------
// Polyline length accumulator package
// Widths, types and the controller-to-datapath command and status bundles.
// ----------------------------------------------------------------------------
package pla_pkg;

  localparam int COORD_BITS  = 24;
  localparam int LENGTH_BITS = 32;
  // Coordinate difference magnitude needs one bit more than a coordinate.
  localparam int DIFF_BITS   = COORD_BITS + 1;
  // Sum of three squares, kept at an even width for the root recurrence.
  localparam int SUM_BITS    = 2 * DIFF_BITS;
  localparam int ROOT_BITS   = SUM_BITS / 2;
  localparam int REM_BITS    = ROOT_BITS + 3;
  localparam int STEP_BITS   = $clog2(ROOT_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [LENGTH_BITS-1:0]       length_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic  load;          // capture the incoming point
    logic  sq_en;         // square one axis difference into the sum
    logic  sq_first;      // first axis: restart sum and root registers
    axis_e axis;          // axis being squared
    logic  closing;       // segment is last point back to first point
    logic  root_step;     // one digit of the square root
    logic  accumulate;    // add the segment length to the total
    logic  advance_prior; // current point becomes the prior point
    logic  emit;          // load the result register and clear the total
  } pla_cmd_t;

  typedef struct packed {
    logic have_first; // a first point of the polyline is stored
    logic last;       // the point in work ends the polyline
    logic closed;     // closed mode register
    logic out_free;   // result register can take a new result
  } pla_status_t;

endpackage

>>> sv/pla_interfaces.sv
// ----------------------------------------------------------------------------
// Polyline length accumulator channels
// Point input, length result and closed-mode configuration channels.
// ----------------------------------------------------------------------------
interface pla_point_if;
  import pla_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface pla_length_if;
  import pla_pkg::*;
  logic    valid;
  logic    ready;
  length_t total_length;
  logic    length_saturated;
  modport source (output valid, total_length, length_saturated, input ready);
  modport sink   (input valid, total_length, length_saturated, output ready);
endinterface

interface pla_cfg_if;
  logic valid;
  logic ready;
  logic closed_loop;
  modport source (output valid, closed_loop, input ready);
  modport sink   (input valid, closed_loop, output ready);
endinterface

>>> sv/pla_ctrl.sv
// ----------------------------------------------------------------------------
// Polyline length accumulator controller
// Sequences squaring, square root, accumulation and result hand-off.
// ----------------------------------------------------------------------------
module pla_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  pla_pkg::pla_status_t status_i,
  output pla_pkg::pla_cmd_t    cmd_o
);
  import pla_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_ROOT   = 3'd2;
  localparam logic [2:0] ST_ACCUM  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]           state_q, state_d;
  axis_e                axis_q, axis_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 closing_q, closing_d;

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    step_d     = step_q;
    closing_d  = closing_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    cmd_o.closing = closing_q;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!status_i.have_first) begin
            // A lone point gives no segment; it only ends a one-point polyline.
            if (in_last_i) begin
              state_d = ST_EMIT;
            end
          end else begin
            closing_d = 1'b0;
            axis_d    = AXIS_X;
            state_d   = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        cmd_o.sq_en    = 1'b1;
        cmd_o.sq_first = (axis_q == AXIS_X);
        case (axis_q)
          AXIS_X: axis_d = AXIS_Y;
          AXIS_Y: axis_d = AXIS_Z;
          default: begin
            step_d  = '0;
            state_d = ST_ROOT;
          end
        endcase
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (step_q == STEP_BITS'(ROOT_BITS - 1)) begin
          state_d = ST_ACCUM;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ACCUM: begin
        cmd_o.accumulate    = 1'b1;
        cmd_o.advance_prior = !closing_q;
        if (status_i.last) begin
          if (status_i.closed && !closing_q) begin
            closing_d = 1'b1;
            axis_d    = AXIS_X;
            state_d   = ST_SQUARE;
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      axis_q    <= AXIS_X;
      step_q    <= '0;
      closing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      axis_q    <= axis_d;
      step_q    <= step_d;
      closing_q <= closing_d;
    end
  end

endmodule

>>> sv/pla_datapath.sv
// ----------------------------------------------------------------------------
// Polyline length accumulator datapath
// Point registers, squarer, bit-serial square root, saturating total, result.
// ----------------------------------------------------------------------------
module pla_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pla_pkg::coord_t      in_x_i,
  input  pla_pkg::coord_t      in_y_i,
  input  pla_pkg::coord_t      in_z_i,
  input  logic                 in_last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_closed_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pla_pkg::length_t     out_total_o,
  output logic                 out_sat_o,
  input  pla_pkg::pla_cmd_t    cmd_i,
  output pla_pkg::pla_status_t status_o
);
  import pla_pkg::*;

  coord_t first_x_q, first_y_q, first_z_q;
  coord_t prior_x_q, prior_y_q, prior_z_q;
  coord_t cur_x_q, cur_y_q, cur_z_q;
  logic   last_q;
  logic   have_first_q;
  logic   closed_q;

  logic [SUM_BITS-1:0]  sum_q;
  logic [REM_BITS-1:0]  rem_q;
  logic [ROOT_BITS-1:0] root_q;
  length_t              total_q;
  logic                 ovf_q;

  logic    out_valid_q;
  length_t out_total_q;
  logic    out_sat_q;

  coord_t                   op_a, op_b;
  logic signed [DIFF_BITS:0] diff;
  logic [DIFF_BITS-1:0]     mag;
  logic [SUM_BITS-1:0]      square;
  logic [REM_BITS-1:0]      rem_sh, trial;
  logic [LENGTH_BITS:0]     acc_sum;

  // Operand selection: prior to current, or current back to first.
  always_comb begin
    case (cmd_i.axis)
      AXIS_X: begin
        op_a = cmd_i.closing ? cur_x_q   : prior_x_q;
        op_b = cmd_i.closing ? first_x_q : cur_x_q;
      end
      AXIS_Y: begin
        op_a = cmd_i.closing ? cur_y_q   : prior_y_q;
        op_b = cmd_i.closing ? first_y_q : cur_y_q;
      end
      default: begin
        op_a = cmd_i.closing ? cur_z_q   : prior_z_q;
        op_b = cmd_i.closing ? first_z_q : cur_z_q;
      end
    endcase
  end

  assign diff   = (DIFF_BITS+1)'(op_a) - (DIFF_BITS+1)'(op_b);
  assign mag    = diff[DIFF_BITS] ? DIFF_BITS'(-diff) : diff[DIFF_BITS-1:0];
  assign square = mag * mag;

  // Restoring square root, two radicand bits per step.
  assign rem_sh = {rem_q[REM_BITS-3:0], sum_q[SUM_BITS-1 -: 2]};
  assign trial  = REM_BITS'({root_q, 2'b01});

  assign acc_sum = {1'b0, total_q} + (LENGTH_BITS+1)'(root_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q <= in_x_i;
      cur_y_q <= in_y_i;
      cur_z_q <= in_z_i;
      last_q  <= in_last_i;
      if (!have_first_q) begin
        first_x_q <= in_x_i;
        first_y_q <= in_y_i;
        first_z_q <= in_z_i;
        prior_x_q <= in_x_i;
        prior_y_q <= in_y_i;
        prior_z_q <= in_z_i;
      end
    end
    if (cmd_i.advance_prior) begin
      prior_x_q <= cur_x_q;
      prior_y_q <= cur_y_q;
      prior_z_q <= cur_z_q;
    end
    if (cmd_i.sq_en) begin
      sum_q <= cmd_i.sq_first ? square : sum_q + square;
      if (cmd_i.sq_first) begin
        rem_q  <= '0;
        root_q <= '0;
      end
    end else if (cmd_i.root_step) begin
      sum_q <= {sum_q[SUM_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      out_total_q <= total_q;
      out_sat_q   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
      closed_q     <= 1'b0;
      total_q      <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        closed_q <= cfg_closed_i;
      end
      if (cmd_i.accumulate) begin
        if (acc_sum[LENGTH_BITS]) begin
          total_q <= '1;
          ovf_q   <= 1'b1;
        end else begin
          total_q <= acc_sum[LENGTH_BITS-1:0];
        end
      end
      if (cmd_i.emit) begin
        have_first_q <= 1'b0;
        total_q      <= '0;
        ovf_q        <= 1'b0;
        out_valid_q  <= 1'b1;
      end else begin
        if (cmd_i.load) begin
          have_first_q <= 1'b1;
        end
        if (out_ready_i) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_total_o = out_total_q;
  assign out_sat_o   = out_sat_q;

  assign status_o.have_first = have_first_q;
  assign status_o.last       = last_q;
  assign status_o.closed     = closed_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

>>> sv/polyline_length_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Polyline length accumulator unit
// A first point is only captured. A later point is captured, its three axis
// differences are squared, 25 root steps take the square root and the segment
// length is added to the total. A closed polyline repeats this on its last point for
// the closing segment. A last point then loads the result register, waiting while
// it is full. One point is in work at a time. Reset clears the controller, the
// running total, the overflow flag and closed mode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polyline_length_accumulator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  pla_point_if.sink    point_i,
  pla_cfg_if.sink      cfg_i,
  pla_length_if.source length_o
);
  import pla_pkg::*;

  // The controller and the datapath talk only through these two bundles.
  pla_cmd_t    cmd;
  pla_status_t status;

  // The closed-mode register is always writable; the user must let writes land
  // while the unit is idle (not enforced). It is only read when a last point ends.
  assign cfg_i.ready = 1'b1;

  // The controller owns the input handshake: a point beat is taken only in
  // the idle state, so one point is in work at a time. The result register
  // in the datapath decouples the output side, so a new polyline can start
  // while the previous length still waits to be taken.
  pla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (point_i.valid),
    .in_last_i  (point_i.last_point),
    .in_ready_o (point_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath squares the three axis differences with one shared
  // multiplier, takes a bit-serial square root and adds the truncated
  // segment length to a saturating total.
  pla_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_x_i       (point_i.point_x),
    .in_y_i       (point_i.point_y),
    .in_z_i       (point_i.point_z),
    .in_last_i    (point_i.last_point),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_closed_i (cfg_i.closed_loop),
    .out_valid_o  (length_o.valid),
    .out_ready_i  (length_o.ready),
    .out_total_o  (length_o.total_length),
    .out_sat_o    (length_o.length_saturated),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  // A point beat is never taken while a segment is being worked on.
  `PLA_ASSERT(a_no_accept_busy, clk_i, rst_ni,
    (point_i.valid && point_i.ready) |-> !(cmd.sq_en || cmd.root_step || cmd.accumulate))
  // Only one datapath operation is commanded per cycle.
  `PLA_ASSERT(a_one_op, clk_i, rst_ni,
    $onehot0({cmd.load, cmd.sq_en, cmd.root_step, cmd.accumulate, cmd.emit}))
  // A segment is added only right after the last root step.
  `PLA_ASSERT(a_acc_after_root, clk_i, rst_ni,
    cmd.accumulate |-> $past(cmd.root_step))
  // An emitted result is presented in the following cycle.
  `PLA_ASSERT(a_emit_shows, clk_i, rst_ni, cmd.emit |=> length_o.valid)

endmodule

>>> tb/tb_polyline_length_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Polyline length accumulator testbench
// Streams 3D points through the unit under random source gaps and sink stalls,
// predicts every polyline length on the fly and checks each result beat,
// covering open and closed mode, single points, zero segments, mode changes in
// the middle of a polyline and saturation of the running total.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_polyline_length_accumulator_unit;
  import pla_pkg::*;

  // Clock period is 10 ns; RESET_CYCLES sets how long reset is held.
  localparam int RESET_CYCLES = 12;
  // Settling time after a phase; it covers a closed last point with margin.
  localparam int SETTLE_CYCLES = 64;
  // Longest stretch without any beat before the run is declared hung.
  localparam int STALL_LIMIT = 3000;
  // After this many checked results the sink holds off for a long stretch.
  localparam int HOLD_AFTER = 40;
  localparam int HOLD_CYCLES = 400;
  // Enough alternating corner points to push the total past its maximum.
  localparam int LONG_POINTS = 160;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_POINTS = 42;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam longint unsigned LENGTH_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_beat_t;

  typedef struct {
    length_t total;
    logic    saturated;
  } length_result_t;

  logic clk;
  logic rst_n;

  pla_point_if  point_bus ();
  pla_cfg_if    cfg_bus ();
  pla_length_if length_bus ();

  polyline_length_accumulator_unit dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .point_i  (point_bus),
    .cfg_i    (cfg_bus),
    .length_o (length_bus)
  );

  // Points waiting to be offered, and lengths waiting to come out.
  point_beat_t    pending_points[$];
  length_result_t expected_lengths[$];

  // Our own copy of the unit's state, advanced on every accepted point beat.
  logic            closed_mode = 1'b0;
  point_beat_t     line_first;
  point_beat_t     line_prior;
  int              line_points = 0;
  longint unsigned line_total = 0;
  logic            line_overflow = 1'b0;

  // Handshake bookkeeping shared between the clocked processes.
  logic point_taken = 1'b0;
  logic length_taken = 1'b0;
  int   point_gap = 0;
  logic point_burst = 1'b0;
  int   length_wait = 0;
  logic length_burst = 1'b0;
  int   hold_left = 0;
  int   stall_cycles = 0;

  // Run statistics.
  int points_queued = 0;
  int points_accepted = 0;
  int lengths_checked = 0;
  int closed_lengths = 0;
  int saturated_lengths = 0;
  int mode_writes = 0;
  int mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input of the unit is known from time zero; reset is released on a
  // falling edge so it never races the rising edge.
  initial begin
    rst_n = 1'b0;
    point_bus.valid = 1'b0;
    point_bus.point_x = '0;
    point_bus.point_y = '0;
    point_bus.point_z = '0;
    point_bus.last_point = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.closed_loop = 1'b0;
    length_bus.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Length prediction
  // --------------------------------------------------------------------------

  // Euclidean distance between two points: the squared differences are summed
  // exactly (16 fraction bits) and the integer square root is taken, rounded
  // toward zero, which leaves 8 fraction bits.
  function automatic longint unsigned segment_length(point_beat_t a, point_beat_t b);
    longint          dx;
    longint          dy;
    longint          dz;
    longint unsigned sq_sum;
    longint unsigned root;
    longint unsigned trial;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    sq_sum = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    root = 0;
    // The sum stays below 2^50, so the root fits in 26 bits.
    for (int bit_pos = 26; bit_pos >= 0; bit_pos--) begin
      trial = root | (64'd1 << bit_pos);
      if (trial * trial <= sq_sum) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Adds one segment to the running total, clamping at the maximum length and
  // remembering that the clamp happened until the result goes out.
  task automatic add_segment(input longint unsigned seg);
    longint unsigned sum;
    sum = line_total + seg;
    if (sum > LENGTH_MAX) begin
      line_total = LENGTH_MAX;
      line_overflow = 1'b1;
    end else begin
      line_total = sum;
    end
  endtask

  // Advances the predicted state by one accepted point. Only a point with
  // last_point set produces a result; the closed-mode bit is looked at only
  // then, so a mode change in the middle of a polyline takes effect on it.
  task automatic predict_point(input point_beat_t p);
    length_result_t res;
    if (line_points == 0) begin
      line_first = p;
      line_points = 1;
    end else begin
      add_segment(segment_length(line_prior, p));
      line_points = 2;
    end
    line_prior = p;
    if (p.last) begin
      // A single-point polyline reports zero even in closed mode. With two
      // points in closed mode the one segment is counted out and back.
      if (line_points >= 2 && closed_mode) begin
        add_segment(segment_length(p, line_first));
        closed_lengths++;
      end
      if (line_points >= 2) begin
        res.total = length_t'(line_total);
        res.saturated = line_overflow;
      end else begin
        res.total = '0;
        res.saturated = 1'b0;
      end
      if (res.saturated) begin
        saturated_lengths++;
      end
      expected_lengths.push_back(res);
      line_points = 0;
      line_total = 0;
      line_overflow = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Point driver: offers queued points on the falling edge. After each point
  // it draws how long to stay idle before the next one; now and then it flips
  // into a burst stretch with no idling at all.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : point_driver
    point_beat_t beat;
    if (!rst_n) begin
      point_bus.valid <= 1'b0;
    end else if (!point_bus.valid || point_taken) begin
      if (point_gap > 0) begin
        point_gap--;
        point_bus.valid <= 1'b0;
      end else if (pending_points.size() != 0) begin
        beat = pending_points.pop_front();
        point_bus.point_x <= beat.x;
        point_bus.point_y <= beat.y;
        point_bus.point_z <= beat.z;
        point_bus.last_point <= beat.last;
        point_bus.valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) begin
          point_burst = !point_burst;
        end
        point_gap = point_burst ? 0 : $urandom_range(0, 12);
      end else begin
        point_bus.valid <= 1'b0;
      end
    end
    point_taken = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Length sink: after each result beat it stalls for a random stretch, none in a
  // burst. Once in the run it holds ready low for a long stretch so that the
  // result register stays full and the unit has to stall its point input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : length_sink
    if (!rst_n) begin
      length_bus.ready <= 1'b0;
    end else begin
      if (length_taken) begin
        if ($urandom_range(0, 29) == 0) begin
          length_burst = !length_burst;
        end
        length_wait = length_burst ? 0 : $urandom_range(0, 12);
        if (lengths_checked == HOLD_AFTER) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        length_bus.ready <= 1'b0;
      end else if (length_wait != 0) begin
        length_wait--;
        length_bus.ready <= 1'b0;
      end else begin
        length_bus.ready <= 1'b1;
      end
    end
    length_taken = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: samples all three channels on the rising edge. A result is
  // checked before a point of the same cycle is predicted, since a result can
  // never belong to a point accepted in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    length_result_t want;
    point_beat_t    seen;
    if (rst_n) begin
      if (length_bus.valid && length_bus.ready) begin
        length_taken = 1'b1;
        if (expected_lengths.size() == 0) begin
          $error("Unexpected length beat: total_length %0d, length_saturated %0b",
                 length_bus.total_length, length_bus.length_saturated);
          mismatches++;
        end else begin
          want = expected_lengths.pop_front();
          lengths_checked++;
          if (length_bus.total_length !== want.total) begin
            $error("total_length mismatch: expected %0d, actual %0d",
                   want.total, length_bus.total_length);
            mismatches++;
          end
          if (length_bus.length_saturated !== want.saturated) begin
            $error("length_saturated mismatch: expected %0b, actual %0b",
                   want.saturated, length_bus.length_saturated);
            mismatches++;
          end
        end
      end
      if (point_bus.valid && point_bus.ready) begin
        seen.x = point_bus.point_x;
        seen.y = point_bus.point_y;
        seen.z = point_bus.point_z;
        seen.last = point_bus.last_point;
        predict_point(seen);
        point_taken = 1'b1;
        points_accepted++;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        closed_mode = cfg_bus.closed_loop;
        mode_writes++;
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (point_bus.valid && point_bus.ready) ||
        (length_bus.valid && length_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat on any channel for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_point(input coord_t x, input coord_t y, input coord_t z,
                             input logic last);
    point_beat_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    pending_points.push_back(p);
    points_queued++;
  endtask

  // Writes the closed-mode bit; only called while the unit is idle.
  task automatic set_closed_mode(input logic mode);
    @(negedge clk);
    cfg_bus.closed_loop <= mode;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Waits until every queued point is taken and every length has come out,
  // then lets the unit finish any point that produces no result.
  task automatic finish_phase();
    while (points_accepted != points_queued || expected_lengths.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Coordinates lean toward the extremes, zero and a small region around the
  // origin, with plenty of fully random values so that every bit toggles.
  function automatic coord_t random_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3, 4: return coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly short polylines, some single points and some repeated points.
  task automatic queue_random_polyline(output int count);
    int     n;
    coord_t x;
    coord_t y;
    coord_t z;
    case ($urandom_range(0, 9))
      0: n = 1;
      7, 8: n = $urandom_range(6, 12);
      default: n = $urandom_range(2, 5);
    endcase
    x = random_coord();
    y = random_coord();
    z = random_coord();
    for (int i = 0; i < n; i++) begin
      // Occasionally repeat the previous point to get a zero-length segment.
      if (i == 0 || $urandom_range(0, 7) != 0) begin
        x = random_coord();
        y = random_coord();
        z = random_coord();
      end
      queue_point(x, y, z, i == n - 1);
    end
    count = n;
  endtask

  // Bounces between opposite corners of the coordinate cube; each segment is
  // close to the longest possible, so the total saturates before the end.
  task automatic queue_long_polyline();
    coord_t c;
    for (int i = 0; i < LONG_POINTS; i++) begin
      c = (i % 2 != 0) ? COORD_MAX - coord_t'($urandom_range(0, 255))
                       : COORD_MIN + coord_t'($urandom_range(0, 255));
      queue_point(c, c, c, i == LONG_POINTS - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int queued_in_phase;
    int n;
    logic mode;
    @(posedge rst_n);

    // Open mode straight out of reset: a lone extreme point, the longest
    // possible segment, exact segments and a zero-length segment.
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    queue_point(0, 0, 0, 1'b0);
    queue_point(768, 1024, 0, 1'b0);
    queue_point(768, 1024, -1536, 1'b1);
    queue_point(-5, 7, -9, 1'b0);
    queue_point(-5, 7, -9, 1'b1);
    finish_phase();

    // Closed mode: a lone point still gives zero, two points count the segment
    // twice, and a triangle and a mixed-sign quad add the closing edge.
    set_closed_mode(1'b1);
    queue_point(100, -200, 300, 1'b1);
    queue_point(0, 0, 0, 1'b0);
    queue_point(0, 0, 2560, 1'b1);
    queue_point(0, 0, 0, 1'b0);
    queue_point(768, 0, 0, 1'b0);
    queue_point(768, 1024, 0, 1'b1);
    queue_point(COORD_MIN, COORD_MAX, 0, 1'b0);
    queue_point(COORD_MAX, COORD_MIN, 0, 1'b0);
    queue_point(1, -1, COORD_MIN, 1'b0);
    queue_point(-1, 1, COORD_MAX, 1'b1);

    // The mode changes halfway through a polyline; the value present when the
    // last point arrives is the one that counts.
    queue_point(256, 256, 256, 1'b0);
    queue_point(-256, 512, 0, 1'b0);
    finish_phase();
    set_closed_mode(1'b0);
    queue_point(1000, -1000, 5, 1'b1);
    queue_point(0, 0, 0, 1'b0);
    queue_point(COORD_MIN, 0, 0, 1'b0);
    finish_phase();
    set_closed_mode(1'b1);
    queue_point(0, COORD_MAX, 0, 1'b1);
    finish_phase();

    // Random phases, each under its own mode setting. Two of them carry a
    // saturating polyline, and some end in the middle of a polyline so the
    // next mode write lands mid-line.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = (phase < 2) ? logic'(phase) : logic'($urandom_range(0, 1));
      if (phase == 3) begin
        mode = 1'b0;
      end else if (phase == 6) begin
        mode = 1'b1;
      end
      set_closed_mode(mode);
      if (phase == 3 || phase == 6) begin
        queue_long_polyline();
      end
      queued_in_phase = 0;
      while (queued_in_phase < PHASE_POINTS) begin
        queue_random_polyline(n);
        queued_in_phase += n;
      end
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          queue_point(random_coord(), random_coord(), random_coord(), 1'b0);
        end
      end
      finish_phase();
    end

    // Close whatever polyline may still be open.
    queue_point(random_coord(), random_coord(), random_coord(), 1'b1);
    finish_phase();

    $display("Covered %0d points and %0d lengths: %0d closed, %0d saturated, %0d mode writes.",
             points_accepted, lengths_checked, closed_lengths, saturated_lengths,
             mode_writes);
    if (mismatches == 0 && expected_lengths.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
